// ===== src/label_bounding_box_builder_macros.svh =====
// ----------------------------------------------------------------------------
// Label bounding box builder: assertion macros
// Clocked on clk and disabled during rst. Each use names its own label.
// ----------------------------------------------------------------------------
`ifndef LABEL_BOUNDING_BOX_BUILDER_MACROS_SVH
`define LABEL_BOUNDING_BOX_BUILDER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LBBB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LBBB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lbbb_pkg.sv =====
// ----------------------------------------------------------------------------
// lbbb_pkg
// Shared types and constants of the label bounding box builder.
// ----------------------------------------------------------------------------
package lbbb_pkg;

  localparam int MAX_OBJECTS_DEF = 64;
  localparam int LABEL_COUNT_DEF = 1024;

  localparam int LABEL_W = 10;  // label field width
  localparam int COORD_W = 12;  // pixel coordinate width
  localparam int OFS_W   = 13;  // frame offset register width
  localparam int POS_W   = 14;  // shifted coordinate width

  typedef enum logic [1:0] {
    KIND_MARK  = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_READ  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef enum logic [0:0] {
    REG_X_OFFSET = 1'b0,
    REG_Y_OFFSET = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_LOOKUP,
    ST_ENTRY,
    ST_RD_ISSUE,
    ST_RD_LOAD
  } state_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x_min;
    logic signed [POS_W-1:0] x_max;
    logic signed [POS_W-1:0] y_min;
    logic signed [POS_W-1:0] y_max;
  } box_t;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    box_t               box;
  } entry_t;

endpackage

// ===== src/lbbb_box_merge.sv =====
// ----------------------------------------------------------------------------
// lbbb_box_merge
// Widens a stored box so that it covers one more shifted pixel position.
// ----------------------------------------------------------------------------
module lbbb_box_merge (
  input  lbbb_pkg::box_t                     cur,
  input  logic signed [lbbb_pkg::POS_W-1:0]  px,
  input  logic signed [lbbb_pkg::POS_W-1:0]  py,
  output lbbb_pkg::box_t                     merged
);
  import lbbb_pkg::*;

  always_comb begin
    merged.x_min = (px < cur.x_min) ? px : cur.x_min;
    merged.x_max = (px > cur.x_max) ? px : cur.x_max;
    merged.y_min = (py < cur.y_min) ? py : cur.y_min;
    merged.y_max = (py > cur.y_max) ? py : cur.y_max;
  end

endmodule

// ===== src/label_bounding_box_builder.sv =====
// ----------------------------------------------------------------------------
// label_bounding_box_builder
// Collects min/max boxes of listed labels from a pixel stream and reads them
// out in order of first appearance.
// ----------------------------------------------------------------------------
//
//   channel  handshake              payload
//   -------  ---------------------  ------------------------------------------
//   in       in_valid / in_ready    kind, pixel_label, col, row
//   out      out_valid / out_ready  box_label, x_min, x_max, y_min, y_max,
//                                   last, overflow
//   cfg      cfg_write              cfg_index, cfg_data (x/y offset)
//
// One item at a time. Clear ends when accepted; mark then writes the label
// memory; pixel does a label memory read, entry memory read and write back,
// stopping after the label read if the label is zero or not listed. Readout
// moves entries one at a time, bound by the single entry memory read port and
// the output register. After reset the min(LABEL_COUNT, 1024) label memory
// entries are swept clean, one a cycle, with in_ready low. A stalled output
// holds the readout; new items are taken once the last beat is registered.
// ----------------------------------------------------------------------------
`include "label_bounding_box_builder_macros.svh"

module label_bounding_box_builder #(
  parameter int MAX_OBJECTS = lbbb_pkg::MAX_OBJECTS_DEF,
  parameter int LABEL_COUNT = lbbb_pkg::LABEL_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic signed [lbbb_pkg::OFS_W-1:0]   cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          kind,
  input  logic [lbbb_pkg::LABEL_W-1:0]        pixel_label,
  input  logic [lbbb_pkg::COORD_W-1:0]        col,
  input  logic [lbbb_pkg::COORD_W-1:0]        row,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [lbbb_pkg::LABEL_W-1:0]        box_label,
  output logic signed [lbbb_pkg::POS_W-1:0]   x_min,
  output logic signed [lbbb_pkg::POS_W-1:0]   x_max,
  output logic signed [lbbb_pkg::POS_W-1:0]   y_min,
  output logic signed [lbbb_pkg::POS_W-1:0]   y_max,
  output logic                                last,
  output logic                                overflow
);
  import lbbb_pkg::*;

  localparam int LABEL_SPAN = 1 << LABEL_W;
  localparam int LBL_DEPTH  = (LABEL_COUNT < LABEL_SPAN) ? LABEL_COUNT : LABEL_SPAN;
  localparam int LBL_AW     = $clog2(LBL_DEPTH);
  localparam int EW         = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int CW         = $clog2(MAX_OBJECTS + 1);

  // label memory word: listed bit on top, last slot index below
  logic [EW:0]   label_mem [LBL_DEPTH];
  entry_t        entry_mem [MAX_OBJECTS];

  state_t state, state_next;

  logic signed [OFS_W-1:0] x_offset, y_offset;

  logic [1:0]              item_kind;
  logic [LABEL_W-1:0]      item_label;
  logic signed [POS_W-1:0] item_x, item_y;

  logic [CW-1:0]     count, count_next;
  logic              overflow_flag, overflow_next;
  logic [CW-1:0]     rd_idx, rd_idx_next;
  logic [LBL_AW-1:0] sweep_addr;

  logic              lm_re, lm_we;
  logic [LBL_AW-1:0] lm_waddr;
  logic [EW:0]       lm_wdata, lm_rdata;
  logic              em_re, em_we;
  logic [EW-1:0]     em_raddr, em_waddr;
  entry_t            em_wdata, em_rdata;

  logic                    accept, load_out, hit, item_in_range;
  logic [EW-1:0]           slot;
  logic signed [POS_W-1:0] px, py;
  box_t                    merged;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE);

  // col and row are at most 4095, so the shifted value always fits 14 bits
  assign px = $signed({2'b00, col}) + POS_W'(x_offset);
  assign py = $signed({2'b00, row}) + POS_W'(y_offset);

  assign item_in_range = (32'(item_label) < LBL_DEPTH);
  assign slot          = lm_rdata[EW-1:0];
  // a slot is live only if it lies below the count and its entry names the label
  assign hit = (CW'(slot) < count) && (em_rdata.label == item_label);

  lbbb_box_merge u_merge (
    .cur    (em_rdata.box),
    .px     (item_x),
    .py     (item_y),
    .merged (merged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      x_offset <= '0;
      y_offset <= '0;
    end else if (cfg_write) begin
      if (cfg_index == REG_X_OFFSET) x_offset <= cfg_data;
      else                           y_offset <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_kind  <= kind;
      item_label <= pixel_label;
      item_x     <= px;
      item_y     <= py;
    end
  end

  always_ff @(posedge clk) begin
    if (lm_re) lm_rdata <= label_mem[pixel_label[LBL_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (lm_we) label_mem[lm_waddr] <= lm_wdata;
  end

  always_ff @(posedge clk) begin
    if (em_re) em_rdata <= entry_mem[em_raddr];
  end

  always_ff @(posedge clk) begin
    if (em_we) entry_mem[em_waddr] <= em_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_SWEEP;
      count         <= '0;
      overflow_flag <= 1'b0;
      rd_idx        <= '0;
      sweep_addr    <= '0;
    end else begin
      state         <= state_next;
      count         <= count_next;
      overflow_flag <= overflow_next;
      rd_idx        <= rd_idx_next;
      if (state == ST_SWEEP) sweep_addr <= sweep_addr + 1'b1;
    end
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    overflow_next = overflow_flag;
    rd_idx_next   = rd_idx;
    lm_re         = 1'b0;
    lm_we         = 1'b0;
    lm_waddr      = item_label[LBL_AW-1:0];
    lm_wdata      = {1'b1, slot};
    em_re         = 1'b0;
    em_raddr      = slot;
    em_we         = 1'b0;
    em_waddr      = slot;
    em_wdata      = '{label: item_label, box: merged};
    load_out      = 1'b0;
    unique case (state)
      ST_SWEEP: begin
        lm_we    = 1'b1;
        lm_waddr = sweep_addr;
        lm_wdata = '0;
        if (sweep_addr == LBL_AW'(LBL_DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          lm_re = 1'b1;
          case (kind) inside
            KIND_MARK, KIND_PIXEL: state_next = ST_LOOKUP;
            KIND_READ: begin
              rd_idx_next = '0;
              state_next  = (count == '0) ? ST_IDLE : ST_RD_ISSUE;
            end
            default: begin
              count_next    = '0;
              overflow_next = 1'b0;
            end
          endcase
        end
      end
      ST_LOOKUP: begin
        state_next = ST_IDLE;
        if (item_kind == KIND_MARK) begin
          lm_we = item_in_range;
        end else if (item_label != '0 && item_in_range && lm_rdata[EW]) begin
          em_re      = 1'b1;
          state_next = ST_ENTRY;
        end
      end
      ST_ENTRY: begin
        state_next = ST_IDLE;
        if (hit) begin
          em_we = 1'b1;
        end else if (count < CW'(MAX_OBJECTS)) begin
          // open a new entry at the end of the table
          em_we      = 1'b1;
          em_waddr   = count[EW-1:0];
          em_wdata   = '{label: item_label,
                         box: '{x_min: item_x, x_max: item_x,
                                y_min: item_y, y_max: item_y}};
          lm_we      = 1'b1;
          lm_wdata   = {1'b1, count[EW-1:0]};
          count_next = count + 1'b1;
        end else begin
          overflow_next = 1'b1;
        end
      end
      ST_RD_ISSUE: begin
        // read only when the output register is free by the next edge
        if (!out_valid || out_ready) begin
          em_re      = 1'b1;
          em_raddr   = rd_idx[EW-1:0];
          state_next = ST_RD_LOAD;
        end
      end
      ST_RD_LOAD: begin
        load_out    = 1'b1;
        rd_idx_next = rd_idx + 1'b1;
        state_next  = (rd_idx + 1'b1 == count) ? ST_IDLE : ST_RD_ISSUE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      box_label <= em_rdata.label;
      x_min     <= em_rdata.box.x_min;
      x_max     <= em_rdata.box.x_max;
      y_min     <= em_rdata.box.y_min;
      y_max     <= em_rdata.box.y_max;
      last      <= (rd_idx + 1'b1 == count);
      overflow  <= overflow_flag;
    end
  end

  `LBBB_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(MAX_OBJECTS), "entry count above capacity")
  `LBBB_ASSERT_NEXT(a_new_entry_counts, state == ST_ENTRY && !hit && em_we, count == $past(count) + 1'b1, "new entry did not advance count")
  `LBBB_ASSERT_NOW(a_overflow_when_full, $rose(overflow_flag), count == CW'(MAX_OBJECTS), "overflow set with free entries")
  `LBBB_ASSERT_NOW(a_quiet_sweep, state == ST_SWEEP, !out_valid && !in_ready, "activity during label sweep")

endmodule

// ===== dv/tb_label_bounding_box_builder.sv =====
// ----------------------------------------------------------------------------
// tb_label_bounding_box_builder
// Self-checking bench for the label bounding box builder. A queue-fed driver
// sends mark, pixel, readout and clear beats under random gaps. A monitor
// checks every box beat against a scoreboard of predicted boxes, built from
// the same beats at acceptance. Offsets are reprogrammed between phases while
// the block is idle. Phases cover table overflow and output backpressure.
// ----------------------------------------------------------------------------
module tb_label_bounding_box_builder;
  import lbbb_pkg::*;

  localparam int ITEMS          = 410;
  localparam int MAX_BOXES      = 64;
  localparam int LABELS         = 1024;
  localparam int SETTLE_CYCLES  = 12;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [OFS_W-1:0] OFS_MIN = 13'h1000;
  localparam logic [OFS_W-1:0] OFS_MAX = 13'h0FFF;

  typedef struct packed {
    kind_t              kind;
    logic [LABEL_W-1:0] label;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } scan_item_t;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic [POS_W-1:0]   x_lo;
    logic [POS_W-1:0]   x_hi;
    logic [POS_W-1:0]   y_lo;
    logic [POS_W-1:0]   y_hi;
    logic               last;
    logic               ovf;
  } box_beat_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  reg_idx_t                  cfg_index = REG_X_OFFSET;
  logic signed [OFS_W-1:0]   cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  kind_t                     kind = KIND_MARK;
  logic [LABEL_W-1:0]        pixel_label = '0;
  logic [COORD_W-1:0]        col = '0;
  logic [COORD_W-1:0]        row = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [LABEL_W-1:0]        box_label;
  logic signed [POS_W-1:0]   x_min;
  logic signed [POS_W-1:0]   x_max;
  logic signed [POS_W-1:0]   y_min;
  logic signed [POS_W-1:0]   y_max;
  logic                      last;
  logic                      overflow;

  label_bounding_box_builder dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .pixel_label(pixel_label), .col(col), .row(row),
    .out_valid(out_valid), .out_ready(out_ready),
    .box_label(box_label), .x_min(x_min), .x_max(x_max),
    .y_min(y_min), .y_max(y_max), .last(last), .overflow(overflow)
  );

  // Predicted block state
  logic signed [OFS_W-1:0] x_ofs = '0;
  logic signed [OFS_W-1:0] y_ofs = '0;
  bit   label_listed [LABELS];
  bit   slot_valid [LABELS];
  int   slot_index [LABELS];
  logic [LABEL_W-1:0] entry_label [MAX_BOXES];
  int   x_lo [MAX_BOXES];
  int   x_hi [MAX_BOXES];
  int   y_lo [MAX_BOXES];
  int   y_hi [MAX_BOXES];
  int   box_count = 0;
  bit   box_overflow = 1'b0;

  scan_item_t stim_queue[$];
  box_beat_t  box_beats_due[$];
  scan_item_t cur_item;
  box_beat_t  want_beat;

  int   mismatches = 0;
  int   items_sent = 0;
  int   quiet_cycles = 0;
  bit   tx_idle = 1'b0;
  bit   rx_idle = 1'b0;
  int   tx_gap = 0;
  int   rx_wait = 0;
  int   stall_left = 0;
  int   hold_req = 0;
  int   hold_done = 0;
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int clamp_pos(int v);
    if (v > 8191) return 8191;
    if (v < -8192) return -8192;
    return v;
  endfunction

  function automatic void apply_item(scan_item_t it);
    int px;
    int py;
    int s;
    box_beat_t b;
    case (it.kind)
      KIND_MARK: label_listed[it.label] = 1'b1;
      KIND_PIXEL: begin
        if (it.label != '0 && label_listed[it.label]) begin
          px = clamp_pos(int'(it.col) + int'(x_ofs));
          py = clamp_pos(int'(it.row) + int'(y_ofs));
          if (slot_valid[it.label]) begin
            s = slot_index[it.label];
            if (px < x_lo[s]) x_lo[s] = px;
            if (px > x_hi[s]) x_hi[s] = px;
            if (py < y_lo[s]) y_lo[s] = py;
            if (py > y_hi[s]) y_hi[s] = py;
          end else if (box_count < MAX_BOXES) begin
            s = box_count;
            entry_label[s] = it.label;
            x_lo[s] = px;
            x_hi[s] = px;
            y_lo[s] = py;
            y_hi[s] = py;
            slot_index[it.label] = s;
            slot_valid[it.label] = 1'b1;
            box_count = s + 1;
          end else begin
            box_overflow = 1'b1;
          end
        end
      end
      KIND_READ: begin
        for (int k = 0; k < box_count; k++) begin
          b.label = entry_label[k];
          b.x_lo  = x_lo[k][POS_W-1:0];
          b.x_hi  = x_hi[k][POS_W-1:0];
          b.y_lo  = y_lo[k][POS_W-1:0];
          b.y_hi  = y_hi[k][POS_W-1:0];
          b.last  = (k == box_count - 1);
          b.ovf   = box_overflow;
          box_beats_due.push_back(b);
        end
      end
      default: begin
        // listed labels survive a clear
        foreach (slot_valid[i]) slot_valid[i] = 1'b0;
        box_count = 0;
        box_overflow = 1'b0;
      end
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [POS_W-1:0] got, logic [POS_W-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Driver: hold the beat until accepted, then wait the drawn gap
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_taken)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (stim_queue.size() != 0) begin
        cur_item = stim_queue.pop_front();
        kind        <= cur_item.kind;
        pixel_label <= cur_item.label;
        col         <= cur_item.col;
        row         <= cur_item.row;
        in_valid    <= 1'b1;
        tx_gap = tx_idle ? $urandom_range(0, 19) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    in_taken <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) apply_item('{kind, pixel_label, col, row});
  end

  // Receiver: per-beat stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (hold_req != hold_done) begin
      hold_done++;
      stall_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      if (out_taken) rx_wait = rx_idle ? $urandom_range(0, 19) : 0;
      if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    out_taken <= !rst && out_valid && out_ready;
    if (!rst && out_valid && out_ready) begin
      if (box_beats_due.size() == 0) begin
        report_mismatch("box beat with nothing expected");
      end else begin
        want_beat = box_beats_due.pop_front();
        check_field("box_label", POS_W'(box_label), POS_W'(want_beat.label));
        check_field("x_min", x_min, want_beat.x_lo);
        check_field("x_max", x_max, want_beat.x_hi);
        check_field("y_min", y_min, want_beat.y_lo);
        check_field("y_max", y_max, want_beat.y_hi);
        check_field("last", POS_W'(last), POS_W'(want_beat.last));
        check_field("overflow", POS_W'(overflow), POS_W'(want_beat.ovf));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic push_item(kind_t k, logic [LABEL_W-1:0] lbl, logic [COORD_W-1:0] c,
                           logic [COORD_W-1:0] r, bit counts);
    stim_queue.push_back('{k, lbl, c, r});
    if (counts) items_sent++;
  endtask

  task automatic write_cfg(reg_idx_t idx, logic [OFS_W-1:0] value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    if (idx == REG_X_OFFSET) x_ofs = value;
    else y_ofs = value;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_offsets(logic [OFS_W-1:0] xo, logic [OFS_W-1:0] yo);
    write_cfg(REG_X_OFFSET, xo);
    write_cfg(REG_Y_OFFSET, yo);
  endtask

  // Wait until every beat is sent and every box beat has come back
  task automatic drain_block();
    while (stim_queue.size() != 0 || in_valid || box_beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return COORD_W'($urandom_range(0, 4095));
    endcase
  endfunction

  // Distinct nonzero labels for i below 1023
  function automatic logic [LABEL_W-1:0] pool_label(int start, int i);
    return LABEL_W'(((start + 7 * i) % 1023) + 1);
  endfunction

  initial begin
    int start;
    int n_lbl;
    int n_body;
    int pick;

    foreach (label_listed[i]) begin
      label_listed[i] = 1'b0;
      slot_valid[i] = 1'b0;
      slot_index[i] = 0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: label zero, unlisted label, coordinate and offset extremes,
    // empty readout after clear
    set_offsets('0, '0);
    push_item(KIND_MARK, 10'd0, '0, '0, 1);
    push_item(KIND_MARK, 10'd1, '0, '0, 1);
    push_item(KIND_MARK, 10'd1023, '1, '1, 1);
    push_item(KIND_MARK, 10'd5, '0, '0, 1);
    push_item(KIND_PIXEL, 10'd0, 12'd12, 12'd34, 1);
    push_item(KIND_PIXEL, 10'd7, 12'd1, 12'd1, 1);
    push_item(KIND_PIXEL, 10'd1, '0, '0, 1);
    push_item(KIND_PIXEL, 10'd1, '1, '1, 1);
    push_item(KIND_PIXEL, 10'd1023, '1, '0, 1);
    push_item(KIND_PIXEL, 10'd1023, '0, '1, 1);
    push_item(KIND_PIXEL, 10'd5, 12'd100, 12'd200, 1);
    push_item(KIND_PIXEL, 10'd5, 12'd50, 12'd300, 1);
    push_item(KIND_READ, '0, '0, '0, 1);
    push_item(KIND_CLEAR, '0, '0, '0, 1);
    push_item(KIND_READ, '1, '1, '1, 1);
    push_item(KIND_PIXEL, 10'd5, 12'd10, 12'd10, 1);
    push_item(KIND_READ, '0, '0, '0, 1);
    drain_block();
    set_offsets(OFS_MIN, OFS_MAX);
    push_item(KIND_PIXEL, 10'd1, '0, '1, 1);
    push_item(KIND_PIXEL, 10'd1, '1, '0, 1);
    push_item(KIND_PIXEL, 10'd1023, 12'd2048, 12'd2048, 1);
    push_item(KIND_READ, '0, '0, '0, 1);
    push_item(KIND_CLEAR, '0, '0, '0, 1);
    drain_block();
    set_offsets(OFS_MAX, OFS_MIN);
    push_item(KIND_PIXEL, 10'd1, '1, '0, 1);
    push_item(KIND_PIXEL, 10'd1, '0, '1, 1);
    push_item(KIND_READ, '0, '0, '0, 1);
    drain_block();

    // Random phases of well-formed label scans with some noise
    for (int ph = 0; items_sent < ITEMS; ph++) begin
      case (ph % 5)
        0:       set_offsets(OFS_MIN, OFS_MIN);
        1:       set_offsets(OFS_MAX, OFS_MAX);
        3:       set_offsets(OFS_MAX, OFS_MIN);
        default: set_offsets(OFS_W'($urandom_range(0, 8191)), OFS_W'($urandom_range(0, 8191)));
      endcase
      tx_idle = (ph % 3 != 0) && (ph != 1);
      rx_idle = (ph % 4 != 3);
      start = $urandom_range(0, 1022);
      n_lbl = (ph == 2) ? 70 : $urandom_range(1, 12);
      // stall the output so the block backs up its input
      if (ph == 1) hold_req++;
      if (ph == 2 || $urandom_range(0, 2) == 0) push_item(KIND_CLEAR, '0, '0, '0, 1);
      for (int i = 0; i < n_lbl; i++)
        push_item(KIND_MARK, pool_label(start, i), rand_coord(), rand_coord(), 1);
      if (ph == 1 || ph == 2) begin
        // open one box per label; past the table size these overflow
        for (int i = 0; i < n_lbl; i++)
          push_item(KIND_PIXEL, pool_label(start, i), rand_coord(), rand_coord(), 1);
        if (ph == 1) push_item(KIND_READ, '0, '0, '0, 1);
      end
      n_body = $urandom_range(20, 45);
      for (int j = 0; j < n_body; j++) begin
        pick = $urandom_range(0, 99);
        if (pick < 68)
          push_item(KIND_PIXEL, pool_label(start, $urandom_range(0, n_lbl - 1)),
                    rand_coord(), rand_coord(), 1);
        else if (pick < 76)
          push_item(KIND_PIXEL,
                    ($urandom_range(0, 2) == 0) ? '0 : LABEL_W'($urandom_range(1, 1023)),
                    rand_coord(), rand_coord(), 1);
        else if (pick < 82)
          push_item(KIND_MARK, LABEL_W'($urandom_range(0, 1023)), rand_coord(),
                    rand_coord(), 1);
        else if (pick < 94)
          push_item(KIND_READ, LABEL_W'($urandom_range(0, 1023)), rand_coord(),
                    rand_coord(), 1);
        else
          push_item(KIND_CLEAR, LABEL_W'($urandom_range(0, 1023)), rand_coord(),
                    rand_coord(), 1);
      end
      push_item(KIND_READ, '0, '0, '0, 1);
      drain_block();
    end

    drain_block();
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
